// ----- rtl/core/jlh_pkg.sv -----
package jlh_pkg;

  // Initial value of lanes a and b at the start of every key
  localparam logic [31:0] GOLDEN = 32'h9e37_79b9;

  // Byte index of the last byte in a 12-byte block
  localparam logic [3:0] LAST_POS = 4'd11;

  // Number of mix steps, one pipeline stage each
  localparam int MIX_STAGES = 9;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } lanes_t;

  // Work handed from the front end to the mixer
  typedef struct packed {
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic [31:0] add_c;
    logic [31:0] c_init;  // lane c start value when the job opens a key
    logic        fresh;   // lanes start from their initial values
    logic        closing; // final mix of a key, c becomes the hash
  } job_t;

  // One step of the lookup2 mix; k selects the lane and shift amount
  function automatic lanes_t mix_step(lanes_t l, logic [3:0] k);
    lanes_t r;
    r = l;
    case (k)
      4'd0: r.a = (l.a - l.b - l.c) ^ (l.c >> 13);
      4'd1: r.b = (l.b - l.c - l.a) ^ (l.a << 8);
      4'd2: r.c = (l.c - l.a - l.b) ^ (l.b >> 13);
      4'd3: r.a = (l.a - l.b - l.c) ^ (l.c >> 12);
      4'd4: r.b = (l.b - l.c - l.a) ^ (l.a << 16);
      4'd5: r.c = (l.c - l.a - l.b) ^ (l.b >> 5);
      4'd6: r.a = (l.a - l.b - l.c) ^ (l.c >> 3);
      4'd7: r.b = (l.b - l.c - l.a) ^ (l.a << 10);
      4'd8: r.c = (l.c - l.a - l.b) ^ (l.b >> 15);
      default: r = l;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/jlh_fifo.sv -----
module jlh_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [WIDTH-1:0]               wr_data,
  output logic                           full,
  input  logic                           rd_en,
  output logic [WIDTH-1:0]               rd_data,
  output logic                           empty,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/jlh_front.sv -----
module jlh_front (
  input  logic          clk,
  input  logic          rst,
  // byte stream
  input  logic          push,
  output logic          full,
  input  logic [7:0]    key_byte,
  input  logic          byte_present,
  input  logic          last,
  // configuration
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [31:0]   initial_value,
  // job queue
  input  logic          q_full,
  output logic          job_push,
  output jlh_pkg::job_t job
);

  import jlh_pkg::*;

  logic [31:0] iv_reg;
  logic [31:0] key_c;
  logic [31:0] a_acc;
  logic [31:0] b_acc;
  logic [23:0] c_acc;
  logic [3:0]  pos;
  logic [31:0] key_len;
  logic        has_block;
  logic        pend_final;

  logic        acc;
  logic        blk_done;
  logic [31:0] a_next;
  logic [31:0] b_next;
  logic [23:0] c_next;
  logic [31:0] len_next;
  logic [4:0]  sh;
  logic        key_end;
  logic [31:0] iv_next;

  assign cfg_ready = 1'b1;
  assign full      = q_full || pend_final;
  assign acc       = push && !full;
  assign blk_done  = byte_present && (pos == LAST_POS);
  assign sh        = {pos[1:0], 3'b000};
  // Key closes here; the next key starts from the newest seed
  assign key_end   = (pend_final && !q_full) || (acc && last && !blk_done);
  assign iv_next   = cfg_valid ? initial_value : iv_reg;

  // Gather the byte into its lane word
  always_comb begin
    a_next   = a_acc;
    b_next   = b_acc;
    c_next   = c_acc;
    len_next = key_len + {31'd0, byte_present};
    if (byte_present) begin
      if (pos inside {[4'd0:4'd3]}) begin
        a_next = a_acc | ({24'd0, key_byte} << sh);
      end else if (pos inside {[4'd4:4'd7]}) begin
        b_next = b_acc | ({24'd0, key_byte} << sh);
      end else if (pos inside {[4'd8:4'd10]}) begin
        c_next = c_acc | ({16'd0, key_byte} << sh);
      end
    end
  end

  // Job build: full block, closing step, or deferred closing step
  always_comb begin
    job_push    = 1'b0;
    job.add_a   = a_next;
    job.add_b   = b_next;
    job.add_c   = len_next + {c_next, 8'd0};
    job.c_init  = key_c;
    job.fresh   = !has_block;
    job.closing = 1'b1;
    if (pend_final) begin
      job_push    = !q_full;
      job.add_a   = '0;
      job.add_b   = '0;
      job.add_c   = key_len;
      job.fresh   = 1'b0;
    end else if (acc && blk_done) begin
      job_push    = 1'b1;
      job.add_c   = {key_byte, c_acc};
      job.closing = 1'b0;
    end else if (acc && last) begin
      job_push    = 1'b1;
    end
  end

  // Key state
  always_ff @(posedge clk) begin
    if (rst) begin
      iv_reg     <= '0;
      a_acc      <= '0;
      b_acc      <= '0;
      c_acc      <= '0;
      pos        <= '0;
      key_len    <= '0;
      has_block  <= 1'b0;
      pend_final <= 1'b0;
    end else begin
      if (pend_final) begin
        // closing step waits for room in the job queue
        if (!q_full) begin
          pend_final <= 1'b0;
          key_len    <= '0;
          has_block  <= 1'b0;
        end
      end else if (acc) begin
        if (blk_done || last) begin
          a_acc <= '0;
          b_acc <= '0;
          c_acc <= '0;
          pos   <= '0;
        end else begin
          a_acc <= a_next;
          b_acc <= b_next;
          c_acc <= c_next;
          if (byte_present) begin
            pos <= pos + 1'b1;
          end
        end
        if (blk_done && last) begin
          pend_final <= 1'b1;
          key_len    <= len_next;
          has_block  <= 1'b1;
        end else if (last) begin
          key_len   <= '0;
          has_block <= 1'b0;
        end else begin
          key_len <= len_next;
          if (blk_done) begin
            has_block <= 1'b1;
          end
        end
      end
      if (cfg_valid) begin
        iv_reg <= initial_value;
      end
    end
  end

  // Lane c start value; a write between keys also applies to the open key
  always_ff @(posedge clk) begin
    if (rst) begin
      key_c <= '0;
    end else if (key_end) begin
      key_c <= iv_next;
    end else if (cfg_valid && key_len == '0 && pos == '0) begin
      key_c <= initial_value;
    end
  end

endmodule

// ----- rtl/core/jlh_back.sv -----
module jlh_back #(
  parameter int OUT_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // job queue
  input  logic                         job_valid,
  input  jlh_pkg::job_t                job,
  output logic                         job_pop,
  // result queue
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                         res_push,
  output logic [31:0]                  res_data
);

  import jlh_pkg::*;

  localparam int NS = MIX_STAGES + 1;
  localparam int CW = $clog2(OUT_DEPTH + NS + 1);

  lanes_t        stage_lanes [NS];
  logic [NS-1:0] stage_vld;
  logic [NS-1:0] stage_cls;
  lanes_t        lanes;
  lanes_t        base;
  logic          block_busy;
  logic [CW-1:0] reserved;
  logic          credit_ok;

  // Queued results plus closing jobs in flight: result slots already promised
  always_comb begin
    reserved = CW'(out_count);
    for (int i = 0; i < NS; i++) begin
      reserved = reserved + CW'(stage_vld[i] && stage_cls[i]);
    end
  end

  assign block_busy = |(stage_vld & ~stage_cls);
  assign credit_ok  = (reserved < CW'(OUT_DEPTH));
  assign job_pop    = job_valid && (job.fresh || !block_busy)
                      && (!job.closing || credit_ok);

  assign base.a = job.fresh ? GOLDEN : lanes.a;
  assign base.b = job.fresh ? GOLDEN : lanes.b;
  assign base.c = job.fresh ? job.c_init : lanes.c;

  // Issue stage: add the gathered words into the lanes
  always_ff @(posedge clk) begin
    stage_lanes[0].a <= base.a + job.add_a;
    stage_lanes[0].b <= base.b + job.add_b;
    stage_lanes[0].c <= base.c + job.add_c;
  end

  // Mix pipeline, one step per stage
  for (genvar k = 1; k < NS; k++) begin : g_mix
    always_ff @(posedge clk) begin
      stage_lanes[k] <= mix_step(stage_lanes[k-1], 4'(k - 1));
    end
  end

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld <= '0;
      stage_cls <= '0;
    end else begin
      stage_vld <= {stage_vld[NS-2:0], job_pop};
      stage_cls <= {stage_cls[NS-2:0], job.closing};
    end
  end

  // Mixed lanes of a block carry on into the next job of the key
  always_ff @(posedge clk) begin
    if (stage_vld[NS-1] && !stage_cls[NS-1]) begin
      lanes <= stage_lanes[NS-1];
    end
  end

  assign res_push = stage_vld[NS-1] && stage_cls[NS-1];
  assign res_data = stage_lanes[NS-1].c;

endmodule

// ----- rtl/core/jenkins_lookup2_hash.sv -----
// 32-bit lookup2 hash of byte-serial keys.
// Input queue side: one key byte per request (push while full is low).
// byte_present marks a real byte; last closes the key. A request with
// last and no byte closes the key as is, alone it hashes an empty key.
// Result queue side: hash_value is valid while empty is low, taken by pop.
// Config channel: initial_value is the lane c seed, written with
// cfg_valid/cfg_ready (always ready). A write between keys applies to
// the next key; a write inside a key applies from the key after it.
// Throughput: one byte per cycle while full is low. A key whose last byte
// completes a 12-byte block raises full until its closing step is queued.
// Path of a closing request to its hash: job queue, 10-stage mix
// pipeline, result queue. A job that follows a block of its key issues
// only once that block has left the mix pipeline; short keys arriving
// meanwhile can fill the job queue and raise full.
// Reset (rst, synchronous) empties both queues, clears the seed to zero
// and starts a new key. When pop stays low, results collect in the
// result queue; once its slots are promised the job queue fills and
// full rises.
module jenkins_lookup2_hash #(
  parameter int JOB_DEPTH = 4,
  parameter int OUT_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  key_byte,
  input  logic        byte_present,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] initial_value
);

  import jlh_pkg::*;

  localparam int JW = $bits(job_t);

  logic                         q_full;
  logic                         q_empty;
  logic                         job_push;
  logic                         job_pop;
  job_t                         job_in;
  job_t                         job_out;
  logic [JW-1:0]                job_rd;
  logic [$clog2(JOB_DEPTH+1)-1:0] job_count;
  logic [$clog2(OUT_DEPTH+1)-1:0] out_count;
  logic                         res_push;
  logic [31:0]                  res_data;
  logic                         out_full;

  assign job_out = job_t'(job_rd);

  // Byte gathering and job build
  jlh_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .key_byte      (key_byte),
    .byte_present  (byte_present),
    .last          (last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .initial_value (initial_value),
    .q_full        (q_full),
    .job_push      (job_push),
    .job           (job_in)
  );

  // Job queue between front end and mixer
  jlh_fifo #(
    .WIDTH (JW),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (job_in),
    .full    (q_full),
    .rd_en   (job_pop),
    .rd_data (job_rd),
    .empty   (q_empty),
    .count   (job_count)
  );

  // Mix pipeline
  jlh_back #(
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_empty && (job_count != '0)),
    .job       (job_out),
    .job_pop   (job_pop),
    .out_count (out_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Result queue; slots are reserved at issue so it never overflows
  jlh_fifo #(
    .WIDTH (32),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push && !out_full),
    .wr_data (res_data),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data (hash_value),
    .empty   (empty),
    .count   (out_count)
  );

endmodule

// ----- tb/jenkins_lookup2_hash_tb.sv -----
module jenkins_lookup2_hash_tb;

  typedef struct packed {
    logic [7:0] kb;
    logic       present;
    logic       fin;
  } byte_req_t;

  typedef enum int {READ_STEADY, READ_RANDOM, READ_CLOGGED} read_mode_t;

  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES = 8;
  localparam int PHASE_BYTES = 185;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  key_byte = 8'h00;
  logic        byte_present = 1'b0;
  logic        last = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] hash_value;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] initial_value = 32'h0;

  jenkins_lookup2_hash dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .key_byte     (key_byte),
    .byte_present (byte_present),
    .last         (last),
    .empty        (empty),
    .pop          (pop),
    .hash_value   (hash_value),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .initial_value(initial_value)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Hash state mirror
  logic [31:0] seed;
  logic [31:0] hash_a;
  logic [31:0] hash_b;
  logic [31:0] hash_c;
  logic [23:0] held_c;
  logic [3:0]  byte_pos;
  logic [31:0] key_len;
  logic [31:0] hashes_due[$];

  // Stimulus bookkeeping
  byte_req_t  reqs[$];
  byte_req_t  nxt;
  int         reqs_queued = 0;
  int         reqs_accepted = 0;
  bit         req_taken = 1'b0;
  int         burst_left = 0;
  int         gap_left = 0;
  bit         sender_steady = 1'b0;
  read_mode_t reader_mode = READ_RANDOM;
  int         stall_left = 0;
  int         fail_count = 0;
  logic [31:0] want;

  logic [31:0] seed_list [PHASES] = '{32'hffff_ffff, 32'h0, 32'h1234_5678, 32'h8000_0000,
                                      32'h9e37_79b9, 32'h0000_0001, 32'hdead_beef, 32'h0};

  function automatic void open_key();
    hash_a = jlh_pkg::GOLDEN;
    hash_b = jlh_pkg::GOLDEN;
    hash_c = seed;
    held_c = '0;
    byte_pos = '0;
    key_len = '0;
  endfunction

  // lookup2 mix on the three lanes
  function automatic void scramble();
    hash_a = (hash_a - hash_b - hash_c) ^ (hash_c >> 13);
    hash_b = (hash_b - hash_c - hash_a) ^ (hash_a << 8);
    hash_c = (hash_c - hash_a - hash_b) ^ (hash_b >> 13);
    hash_a = (hash_a - hash_b - hash_c) ^ (hash_c >> 12);
    hash_b = (hash_b - hash_c - hash_a) ^ (hash_a << 16);
    hash_c = (hash_c - hash_a - hash_b) ^ (hash_b >> 5);
    hash_a = (hash_a - hash_b - hash_c) ^ (hash_c >> 3);
    hash_b = (hash_b - hash_c - hash_a) ^ (hash_a << 10);
    hash_c = (hash_c - hash_a - hash_b) ^ (hash_b >> 15);
  endfunction

  // Seed write; lane c picks it up only if no byte of the key is in yet
  function automatic void load_seed(input logic [31:0] v);
    seed = v;
    if (key_len == 0 && byte_pos == 0) hash_c = seed;
  endfunction

  // Fold one accepted request into the hash state
  function automatic void absorb(input logic [7:0] kb, input logic present, input logic fin);
    logic [31:0] wide;
    wide = {24'd0, kb};
    if (present) begin
      if (byte_pos < 4) begin
        hash_a += wide << (8 * byte_pos);
      end else if (byte_pos < 8) begin
        hash_b += wide << (8 * (byte_pos - 4));
      end else if (byte_pos < 11) begin
        held_c = held_c | 24'(wide << (8 * (byte_pos - 8)));
      end else begin
        // full block: c gets bytes 8..11, then mix
        hash_c += {8'd0, held_c} + (wide << 24);
        scramble();
        held_c = '0;
      end
      byte_pos = (byte_pos == 4'd11) ? 4'd0 : byte_pos + 4'd1;
      key_len += 1;
    end
    if (fin) begin
      hash_c += key_len;
      hash_c += {held_c, 8'd0};
      scramble();
      hashes_due.push_back(hash_c);
      open_key();
    end
  endfunction

  function automatic void note_failure(input string what, input logic [31:0] exp_v,
                                       input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t: %s: expected %08h, got %08h", $time, what, exp_v, got_v);
  endfunction

  function automatic void add_req(input logic [7:0] kb, input logic present, input logic fin);
    byte_req_t r;
    r.kb = kb;
    r.present = present;
    r.fin = fin;
    reqs.push_back(r);
    reqs_queued++;
  endfunction

  // Queue one key with random bytes and some ignored empty requests mixed in.
  // Returns the number of requests that do something.
  function automatic int queue_key(input int len, input bit leave_open);
    bit empty_close;
    int cnt;
    empty_close = (len == 0) || ($urandom_range(0, 3) == 0);
    cnt = 0;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) add_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      add_req(8'($urandom_range(0, 255)), 1'b1,
              !leave_open && !empty_close && (i == len - 1));
      cnt++;
    end
    if (!leave_open && empty_close) begin
      add_req(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      cnt++;
    end
    return cnt;
  endfunction

  // Mostly short keys, many around block multiples, a few long ones
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $urandom_range(0, 13);
    if (r < 9) return 12 * $urandom_range(1, 3) + $urandom_range(0, 2) - 1;
    return $urandom_range(14, 70);
  endfunction

  task automatic write_seed(input logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    initial_value <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every request taken and every hash out, then let the pipe settle
  task automatic drain();
    do @(negedge clk); while (reqs_accepted != reqs_queued || hashes_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Request driver: bursts, with gaps between them unless the sender is steady
  always @(negedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else if (!push || req_taken) begin
      req_taken = 1'b0;
      if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (reqs.size() != 0) begin
        nxt = reqs.pop_front();
        key_byte <= nxt.kb;
        byte_present <= nxt.present;
        last <= nxt.fin;
        push <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          if (!sender_steady) gap_left = $urandom_range(1, 10);
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Result reader: no stalls in steady mode; otherwise short random stalls, now and then a long one
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (reader_mode == READ_STEADY) begin
      pop <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = $urandom_range(0, 3);
      pop <= 1'b0;
    end else if ($urandom_range(0, (reader_mode == READ_CLOGGED) ? 59 : 599) == 0) begin
      stall_left = $urandom_range(40, 250);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // Monitor: check results, then track config writes and accepted requests
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (hashes_due.size() == 0) begin
          note_failure("unexpected hash", 32'h0, hash_value);
        end else begin
          want = hashes_due.pop_front();
          if (hash_value !== want) note_failure("hash_value mismatch", want, hash_value);
        end
      end
      if (cfg_valid && cfg_ready) load_seed(initial_value);
      if (push && !full) begin
        absorb(key_byte, byte_present, last);
        reqs_accepted++;
        req_taken = 1'b1;
      end
    end
  end

  initial begin
    int budget;
    seed = '0;
    open_key();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty key, single-byte extremes, full block on the last byte,
    // ignored empty requests and an empty closing request after bytes
    @(posedge clk);
    add_req(8'h00, 1'b0, 1'b1);
    add_req(8'hff, 1'b1, 1'b1);
    add_req(8'h00, 1'b1, 1'b1);
    for (int i = 0; i < 12; i++) add_req(8'hff, 1'b1, i == 11);
    add_req(8'h00, 1'b0, 1'b0);
    add_req(8'h80, 1'b1, 1'b0);
    add_req(8'h00, 1'b0, 1'b0);
    add_req(8'h00, 1'b0, 1'b1);
    add_req(8'h55, 1'b1, 1'b0);
    add_req(8'haa, 1'b1, 1'b1);
    drain();

    // Random phases, each under a new seed and its own pacing
    for (int ph = 0; ph < PHASES; ph++) begin
      sender_steady = (ph == 2) || (ph == 5);
      reader_mode = (ph == 3) ? READ_STEADY : (ph == 4 || ph == 5) ? READ_CLOGGED : READ_RANDOM;
      write_seed(seed_list[ph]);
      @(posedge clk);
      budget = 0;
      while (budget < PHASE_BYTES) budget += queue_key(pick_len(), 1'b0);
      // leave a key open so the next seed write lands mid-key
      if (ph == 1 || ph == 6) void'(queue_key($urandom_range(1, 20), 1'b1));
      if (ph == 4) void'(queue_key(1, 1'b1));
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/jlh_pkg.sv
rtl/core/jlh_fifo.sv
rtl/core/jlh_front.sv
rtl/core/jlh_back.sv
rtl/core/jenkins_lookup2_hash.sv
tb/jenkins_lookup2_hash_tb.sv
